### design/lir_pkg.sv
// ----------------------------------------------------------------------------
// lir_pkg
// Shared types, constants and sequencer states of the linear
// interpolation resampler.
// ----------------------------------------------------------------------------
`default_nettype none

package lir_pkg;

    // sample and frame geometry
    localparam int CHANNELS    = 2;
    localparam int SAMPLE_BITS = 24;
    localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // phase arithmetic, unsigned Q5.24
    localparam int PHASE_W   = 29;
    localparam int PH_SUM_W  = PHASE_W + 1;
    localparam int FRAC_W    = 24;
    localparam logic [PH_SUM_W-1:0] PHASE_ONE  = PH_SUM_W'(32'd16777216);
    localparam logic [PHASE_W-1:0]  STEP_RESET = PHASE_W'(32'd16777216);

    // run length cap per input frame
    localparam int RUN_CAP = 64;
    localparam int RUN_W   = $clog2(RUN_CAP) + 1;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = PHASE_W;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PHASE_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BYPASS     = 2'd1;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        t_sample in_ch0;
        t_sample in_ch1;
    } t_in_frame;

    typedef struct packed {
        t_sample out_ch0;
        t_sample out_ch1;
        logic    last_of_run;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_ACC,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

### design/lir_lerp_unit.sv
// ----------------------------------------------------------------------------
// lir_lerp_unit
// Shared interpolation unit: registers (b - a) * frac, then rounds to
// nearest, adds a and saturates to the sample range.
// ----------------------------------------------------------------------------
`default_nettype none

module lir_lerp_unit (
    input  wire                                i_clk,
    input  wire                                i_load,
    input  wire lir_pkg::t_sample              i_a,
    input  wire lir_pkg::t_sample              i_b,
    input  wire logic [lir_pkg::FRAC_W-1:0]    i_frac,
    output lir_pkg::t_sample                   o_y
);

    localparam int DIFF_W = lir_pkg::SAMPLE_BITS + 1;
    localparam int PROD_W = DIFF_W + lir_pkg::FRAC_W + 1;
    localparam int SUM_W  = lir_pkg::SAMPLE_BITS + 3;
    localparam logic signed [PROD_W-1:0] ROUND_HALF =
        PROD_W'(64'd1 << (lir_pkg::FRAC_W - 1));
    localparam logic signed [SUM_W-1:0] S_MIN =
        -(SUM_W'(64'd1 << (lir_pkg::SAMPLE_BITS - 1)));
    localparam logic signed [SUM_W-1:0] S_MAX =
        SUM_W'((64'd1 << (lir_pkg::SAMPLE_BITS - 1)) - 64'd1);

    logic signed [DIFF_W-1:0]  diff;
    logic signed [DIFF_W:0]    frac_s;
    logic signed [PROD_W-1:0]  r_prod;
    lir_pkg::t_sample          r_a;
    logic signed [PROD_W-1:0]  rounded;
    logic signed [SUM_W-1:0]   sum;

    // difference and multiplier operands
    always_comb begin
        diff   = $signed({i_b[lir_pkg::SAMPLE_BITS-1], i_b})
               - $signed({i_a[lir_pkg::SAMPLE_BITS-1], i_a});
        frac_s = $signed({{(DIFF_W + 1 - lir_pkg::FRAC_W){1'b0}}, i_frac});
    end

    // product register
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= PROD_W'(diff * frac_s);
            r_a    <= i_a;
        end
    end

    // round to nearest, ties upward, then add and saturate
    always_comb begin
        rounded = (r_prod + ROUND_HALF) >>> lir_pkg::FRAC_W;
        sum     = $signed({{3{r_a[lir_pkg::SAMPLE_BITS-1]}}, r_a})
                + $signed(rounded[SUM_W-1:0]);
        if (sum < S_MIN) begin
            o_y = S_MIN[lir_pkg::SAMPLE_BITS-1:0];
        end else if (sum > S_MAX) begin
            o_y = S_MAX[lir_pkg::SAMPLE_BITS-1:0];
        end else begin
            o_y = sum[lir_pkg::SAMPLE_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

### design/linear_interp_resampler.sv
// ----------------------------------------------------------------------------
// linear_interp_resampler
// Stereo linear interpolation resampler with a Q5.24 phase, one shared
// multiplier stepped over the channels by a small sequencer.
// ----------------------------------------------------------------------------
// Each result takes a phase check, a multiply and a capture per channel on the one
// shared multiplier and an output register load, which waits out output stalls.
// Input frames stall while a frame is busy; a first frame is only stored as history
// and a bypass frame goes straight to the output register load.
// Synchronous active-low reset: empty history, zero phase, step of one,
// bypass off, output register empty.
`default_nettype none

module linear_interp_resampler (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // input frames
    input  wire                                  i_valid,
    output logic                                 o_stall,
    input  wire lir_pkg::t_in_frame              i_data,
    // results
    output logic                                 o_valid,
    input  wire                                  i_stall,
    output lir_pkg::t_out_item                   o_data,
    // configuration writes
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [lir_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [lir_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam logic [lir_pkg::CH_W-1:0] CH_LAST = lir_pkg::CH_W'(lir_pkg::CHANNELS - 1);
    localparam logic [lir_pkg::RUN_W-1:0] N_CAP  = lir_pkg::RUN_W'(lir_pkg::RUN_CAP);
    localparam logic [lir_pkg::RUN_W-1:0] N_LAST = lir_pkg::RUN_W'(lir_pkg::RUN_CAP - 1);

    lir_pkg::t_state                  r_state, n_state;
    logic [lir_pkg::PHASE_W-1:0]      r_step, n_step;
    logic                             r_bypass, n_bypass;
    logic                             r_have_prev, n_have_prev;
    logic [lir_pkg::PHASE_W-1:0]      r_phase_acc, n_phase_acc;
    lir_pkg::t_sample                 r_prev [lir_pkg::CHANNELS];
    lir_pkg::t_sample                 n_prev [lir_pkg::CHANNELS];
    lir_pkg::t_sample                 r_cur  [lir_pkg::CHANNELS];
    lir_pkg::t_sample                 n_cur  [lir_pkg::CHANNELS];
    lir_pkg::t_sample                 r_res  [lir_pkg::CHANNELS];
    lir_pkg::t_sample                 n_res  [lir_pkg::CHANNELS];
    logic [lir_pkg::PH_SUM_W-1:0]     r_ph, n_ph;
    logic [lir_pkg::RUN_W-1:0]        r_n, n_n;
    logic [lir_pkg::CH_W-1:0]         r_ch, n_ch;
    logic                             r_byp_run, n_byp_run;
    logic                             r_ovalid, n_ovalid;
    lir_pkg::t_out_item               r_odata, n_odata;

    lir_pkg::t_sample                 cur_in [lir_pkg::CHANNELS];
    lir_pkg::t_sample                 lerp_y;
    logic                             lerp_load;
    logic                             in_acc;
    logic                             out_free;
    logic                             emit;
    logic [lir_pkg::PH_SUM_W-1:0]     ph_sum;
    logic [lir_pkg::PH_SUM_W-1:0]     ph_less_one;

    // handshake
    assign o_stall     = (r_state != lir_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_ovalid;
    assign o_data      = r_odata;

    assign in_acc    = i_valid && (r_state == lir_pkg::ST_IDLE);
    assign out_free  = !r_ovalid || !i_stall;
    assign emit      = (r_ph < lir_pkg::PHASE_ONE) && (r_n != N_CAP);
    assign ph_sum    = r_ph + {1'b0, r_step};
    assign ph_less_one = r_ph - lir_pkg::PHASE_ONE;
    assign lerp_load = (r_state == lir_pkg::ST_MUL);

    assign cur_in[0] = i_data.in_ch0;
    assign cur_in[1] = i_data.in_ch1;

    // shared interpolation unit
    lir_lerp_unit u_lerp (
        .i_clk  (i_clk),
        .i_load (lerp_load),
        .i_a    (r_prev[r_ch]),
        .i_b    (r_cur[r_ch]),
        .i_frac (r_ph[lir_pkg::FRAC_W-1:0]),
        .o_y    (lerp_y)
    );

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lir_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (r_bypass) begin
                        n_state = lir_pkg::ST_OUT;
                    end else if (r_have_prev) begin
                        n_state = lir_pkg::ST_CHECK;
                    end
                end
            end
            lir_pkg::ST_CHECK: begin
                n_state = emit ? lir_pkg::ST_MUL : lir_pkg::ST_IDLE;
            end
            lir_pkg::ST_MUL: begin
                n_state = lir_pkg::ST_ACC;
            end
            lir_pkg::ST_ACC: begin
                n_state = (r_ch == CH_LAST) ? lir_pkg::ST_OUT : lir_pkg::ST_MUL;
            end
            lir_pkg::ST_OUT: begin
                if (out_free) begin
                    n_state = r_byp_run ? lir_pkg::ST_IDLE : lir_pkg::ST_CHECK;
                end
            end
            default: begin
                n_state = lir_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and state updates
    always_comb begin
        n_step      = r_step;
        n_bypass    = r_bypass;
        n_have_prev = r_have_prev;
        n_phase_acc = r_phase_acc;
        n_prev      = r_prev;
        n_cur       = r_cur;
        n_res       = r_res;
        n_ph        = r_ph;
        n_n         = r_n;
        n_ch        = r_ch;
        n_byp_run   = r_byp_run;
        n_ovalid    = r_ovalid && i_stall;
        n_odata     = r_odata;

        case (r_state)
            lir_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (r_bypass) begin
                        n_res     = cur_in;
                        n_byp_run = 1'b1;
                    end else if (!r_have_prev) begin
                        n_prev      = cur_in;
                        n_have_prev = 1'b1;
                    end else begin
                        n_cur     = cur_in;
                        n_ph      = {1'b0, r_phase_acc};
                        n_n       = '0;
                        n_byp_run = 1'b0;
                    end
                end
            end
            lir_pkg::ST_CHECK: begin
                if (emit) begin
                    n_ch = '0;
                end else begin
                    // end of run: wrap the phase and keep this frame
                    if (r_ph >= lir_pkg::PHASE_ONE) begin
                        n_phase_acc = ph_less_one[lir_pkg::PHASE_W-1:0];
                    end else begin
                        n_phase_acc = '0;
                    end
                    n_prev = r_cur;
                end
            end
            lir_pkg::ST_MUL: begin
                n_ch = r_ch;
            end
            lir_pkg::ST_ACC: begin
                n_res[r_ch] = lerp_y;
                n_ch        = r_ch + 1'b1;
            end
            lir_pkg::ST_OUT: begin
                if (out_free) begin
                    n_ovalid            = 1'b1;
                    n_odata.out_ch0     = r_res[0];
                    n_odata.out_ch1     = r_res[1];
                    n_odata.last_of_run = r_byp_run || (ph_sum >= lir_pkg::PHASE_ONE)
                                          || (r_n == N_LAST);
                    if (!r_byp_run) begin
                        n_ph = ph_sum;
                        n_n  = r_n + 1'b1;
                    end
                end
            end
            default: begin
                n_ch = r_ch;
            end
        endcase

        // configuration transaction
        if (i_cfg_valid) begin
            case (i_cfg_index)
                lir_pkg::CFG_IDX_PHASE_STEP: n_step   = i_cfg_data[lir_pkg::PHASE_W-1:0];
                lir_pkg::CFG_IDX_BYPASS:     n_bypass = i_cfg_data[0];
                default: begin
                    n_step = n_step;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lir_pkg::ST_IDLE;
            r_step      <= lir_pkg::STEP_RESET;
            r_bypass    <= 1'b0;
            r_have_prev <= 1'b0;
            r_phase_acc <= '0;
            r_byp_run   <= 1'b0;
            r_ovalid    <= 1'b0;
            for (int c = 0; c < lir_pkg::CHANNELS; c++) begin
                r_prev[c] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_bypass    <= n_bypass;
            r_have_prev <= n_have_prev;
            r_phase_acc <= n_phase_acc;
            r_byp_run   <= n_byp_run;
            r_ovalid    <= n_ovalid;
            r_prev      <= n_prev;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cur   <= n_cur;
        r_res   <= n_res;
        r_ph    <= n_ph;
        r_n     <= n_n;
        r_ch    <= n_ch;
        r_odata <= n_odata;
    end

endmodule

`default_nettype wire

### bench/linear_interp_resampler_test.sv
// ----------------------------------------------------------------------------
// linear_interp_resampler_test
// Self-checking bench for the stereo linear interpolation resampler. A
// bit-exact predictor tracks phase, history and registers, queues the
// interpolated samples each input frame should produce, and every output
// transaction is compared in order against that queue. Directed cases come
// first, then randomised streams over many step and bypass settings, with
// random idling on the input and output.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_interp_resampler_test;

    localparam int RANDOM_ITEMS = 360;
    localparam int MAX_IDLE     = 10;
    localparam int DRAIN_CYCLES = 24;

    // register indexes past the end of the register file
    localparam logic [lir_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_2 = 2'd2;
    localparam logic [lir_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_3 = 2'd3;

    localparam logic [lir_pkg::PHASE_W-1:0] STEP_ONE     =
        lir_pkg::PHASE_W'(lir_pkg::PHASE_ONE);
    localparam logic [lir_pkg::PHASE_W-1:0] STEP_HALF    = lir_pkg::PHASE_W'(32'd8388608);
    localparam logic [lir_pkg::PHASE_W-1:0] STEP_QUARTER = lir_pkg::PHASE_W'(32'd4194304);
    localparam logic [lir_pkg::PHASE_W-1:0] STEP_2_5     = lir_pkg::PHASE_W'(32'd41943040);
    localparam logic [lir_pkg::PHASE_W-1:0] STEP_LOWEST  = lir_pkg::PHASE_W'(32'd262144);
    localparam logic [lir_pkg::PHASE_W-1:0] STEP_HIGHEST = lir_pkg::PHASE_W'(32'd268435456);
    localparam logic [lir_pkg::PHASE_W-1:0] STEP_ALL_SET = '1;

    localparam lir_pkg::t_sample S_MAX = {1'b0, {(lir_pkg::SAMPLE_BITS-1){1'b1}}};
    localparam lir_pkg::t_sample S_MIN = {1'b1, {(lir_pkg::SAMPLE_BITS-1){1'b0}}};
    localparam longint ROUND_HALF = longint'(1) << (lir_pkg::FRAC_W - 1);

    // dut signals
    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_valid     = 1'b0;
    logic                           o_stall;
    lir_pkg::t_in_frame             i_data      = '0;
    logic                           o_valid;
    logic                           i_stall     = 1'b0;
    lir_pkg::t_out_item             o_data;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [lir_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [lir_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    // predictor state and registers
    bit                          have_history = 1'b0;
    logic [lir_pkg::PHASE_W-1:0] phase_acc    = '0;
    lir_pkg::t_sample            hist_ch0     = '0;
    lir_pkg::t_sample            hist_ch1     = '0;
    logic [lir_pkg::PHASE_W-1:0] step_reg     = lir_pkg::STEP_RESET;
    bit                          bypass_reg   = 1'b0;

    // interpolated samples still to come out, oldest first
    lir_pkg::t_out_item pending_samples[$];

    int                 error_count   = 0;
    int                 frames_sent   = 0;
    int                 samples_seen  = 0;
    int                 reg_writes    = 0;
    int                 settings_used = 0;
    int                 sink_hold     = 0;
    bit                 src_idle      = 1'b1;
    bit                 sink_idle     = 1'b1;
    lir_pkg::t_in_frame last_frame    = '0;

    linear_interp_resampler uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #40_000_000;
        $display("timeout with %0d samples still pending", pending_samples.size());
        $display("linear_interp_resampler_test: done, errors");
        $finish;
    end

    // append one expected sample at the back of the queue
    task automatic queue_sample(input lir_pkg::t_out_item r);
        pending_samples.insert(pending_samples.size(), r);
    endtask

    // saturate a wide value to the sample range
    function automatic lir_pkg::t_sample clamp_sample(input longint v);
        if (v < longint'(S_MIN)) v = longint'(S_MIN);
        if (v > longint'(S_MAX)) v = longint'(S_MAX);
        return lir_pkg::t_sample'(v);
    endfunction

    // a + (b - a) * frac, product rounded to nearest with ties upward
    function automatic lir_pkg::t_sample lerp_sample(input lir_pkg::t_sample a,
                                                     input lir_pkg::t_sample b,
                                                     input logic [31:0] frac);
        longint prod;
        prod = (longint'(b) - longint'(a)) * longint'(frac);
        return clamp_sample(longint'(a) + ((prod + ROUND_HALF) >>> lir_pkg::FRAC_W));
    endfunction

    // expected samples for one accepted input frame
    task automatic resample_frame(input lir_pkg::t_in_frame f);
        logic [31:0]        ph;
        int                 n;
        lir_pkg::t_out_item r;
        if (bypass_reg) begin
            r.out_ch0     = f.in_ch0;
            r.out_ch1     = f.in_ch1;
            r.last_of_run = 1'b1;
            queue_sample(r);
        end else if (!have_history) begin
            hist_ch0     = f.in_ch0;
            hist_ch1     = f.in_ch1;
            have_history = 1'b1;
        end else begin
            ph = 32'(phase_acc);
            n  = 0;
            while (ph < 32'(lir_pkg::PHASE_ONE) && n < lir_pkg::RUN_CAP) begin
                r.out_ch0 = lerp_sample(hist_ch0, f.in_ch0, ph);
                r.out_ch1 = lerp_sample(hist_ch1, f.in_ch1, ph);
                ph        = ph + 32'(step_reg);
                n++;
                r.last_of_run = (ph >= 32'(lir_pkg::PHASE_ONE)) || (n == lir_pkg::RUN_CAP);
                queue_sample(r);
            end
            // cap hit while still below one: phase restarts from zero
            if (ph >= 32'(lir_pkg::PHASE_ONE))
                ph = ph - 32'(lir_pkg::PHASE_ONE);
            else
                ph = '0;
            phase_acc = ph[lir_pkg::PHASE_W-1:0];
            hist_ch0  = f.in_ch0;
            hist_ch1  = f.in_ch1;
        end
    endtask

    // output side: random stall per transaction, in-order compare
    always @(posedge i_clk) begin : result_sink
        lir_pkg::t_out_item want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (pending_samples.size() == 0) begin
                    $error("unexpected sample: out_ch0 %0d out_ch1 %0d last_of_run %0b",
                           o_data.out_ch0, o_data.out_ch1, o_data.last_of_run);
                    error_count++;
                end else begin
                    want = pending_samples.pop_front();
                    samples_seen++;
                    if (o_data.out_ch0 !== want.out_ch0) begin
                        $error("out_ch0: expected %0d, got %0d", want.out_ch0, o_data.out_ch0);
                        error_count++;
                    end
                    if (o_data.out_ch1 !== want.out_ch1) begin
                        $error("out_ch1: expected %0d, got %0d", want.out_ch1, o_data.out_ch1);
                        error_count++;
                    end
                    if (o_data.last_of_run !== want.last_of_run) begin
                        $error("last_of_run: expected %0b, got %0b",
                               want.last_of_run, o_data.last_of_run);
                        error_count++;
                    end
                end
                sink_hold = sink_idle ? $urandom_range(0, MAX_IDLE) : 0;
            end
            if (sink_hold > 0) begin
                i_stall <= 1'b1;
                sink_hold--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // one input transaction, with a random lead-in gap
    task automatic send_frame(input lir_pkg::t_in_frame f);
        int gap;
        gap = src_idle ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= f;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        resample_frame(f);
        last_frame = f;
        frames_sent++;
    endtask

    // drop valid, let every pending sample out and the sequencer settle
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // one register write transaction, only while idle
    task automatic write_reg(input logic [lir_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lir_pkg::CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            lir_pkg::CFG_IDX_PHASE_STEP: step_reg   = value;
            lir_pkg::CFG_IDX_BYPASS:     bypass_reg = value[0];
            default: ;
        endcase
        reg_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // new step and bypass setting, upper bypass data bits random
    task automatic configure(input logic [lir_pkg::PHASE_W-1:0] step, input bit byp);
        logic [lir_pkg::CFG_DATA_W-1:0] bdata;
        wait_idle();
        bdata    = lir_pkg::CFG_DATA_W'($urandom);
        bdata[0] = byp;
        write_reg(lir_pkg::CFG_IDX_PHASE_STEP, step);
        write_reg(lir_pkg::CFG_IDX_BYPASS, bdata);
        settings_used++;
    endtask

    function automatic lir_pkg::t_in_frame make_frame(input lir_pkg::t_sample a,
                                                      input lir_pkg::t_sample b);
        lir_pkg::t_in_frame f;
        f.in_ch0 = a;
        f.in_ch1 = b;
        return f;
    endfunction

    function automatic lir_pkg::t_sample pick_extreme();
        case ($urandom_range(0, 3))
            0:       return S_MIN;
            1:       return S_MAX;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    // small random walk from the last sample sent
    function automatic lir_pkg::t_sample nudge(input lir_pkg::t_sample s);
        return clamp_sample(longint'(s) + longint'($urandom_range(0, 2000)) - 1000);
    endfunction

    // mostly full-range noise, some smooth signal, some extremes and some values near zero
    function automatic lir_pkg::t_in_frame rand_frame();
        case ($urandom_range(0, 7))
            0, 1, 2, 3: return make_frame(lir_pkg::t_sample'($urandom),
                                          lir_pkg::t_sample'($urandom));
            4, 5:       return make_frame(nudge(last_frame.in_ch0), nudge(last_frame.in_ch1));
            6:          return make_frame(pick_extreme(), pick_extreme());
            default:    return make_frame(lir_pkg::t_sample'(int'($urandom_range(0, 2)) - 1),
                                          lir_pkg::t_sample'(int'($urandom_range(0, 2)) - 1));
        endcase
    endfunction

    // step mix: mostly up- and downsampling, some tiny, full-range and exact
    function automatic logic [lir_pkg::PHASE_W-1:0] pick_step();
        case ($urandom_range(0, 9))
            0:          return lir_pkg::PHASE_W'($urandom_range(0, 32'(STEP_LOWEST)));
            1, 2, 3, 4: return lir_pkg::PHASE_W'($urandom_range(32'(STEP_ONE) / 8,
                                                                32'(STEP_ONE)));
            5, 6, 7:    return lir_pkg::PHASE_W'($urandom_range(32'(STEP_ONE),
                                                                4 * 32'(STEP_ONE)));
            8:          return lir_pkg::PHASE_W'($urandom);
            default: begin
                case ($urandom_range(0, 5))
                    0:       return STEP_ONE;
                    1:       return STEP_HALF;
                    2:       return STEP_QUARTER;
                    3:       return STEP_ALL_SET;
                    4:       return STEP_LOWEST;
                    default: return STEP_HIGHEST;
                endcase
            end
        endcase
    endfunction

    // reset values: first frame only stored, then one sample per frame
    task automatic test_power_up();
        send_frame(make_frame(S_MAX, S_MIN));
        send_frame(make_frame(S_MIN, S_MAX));
        send_frame(make_frame('0, '1));
        send_frame(make_frame(lir_pkg::t_sample'(1), S_MAX));
        settings_used++;
    endtask

    // half step between extremes, odd differences land on rounding ties
    task automatic test_half_step_rounding();
        configure(STEP_HALF, 1'b0);
        send_frame(make_frame(S_MAX, S_MIN));
        send_frame(make_frame(S_MIN, S_MAX));
        send_frame(make_frame('0, '0));
        send_frame(make_frame('1, lir_pkg::t_sample'(1)));
        send_frame(make_frame(lir_pkg::t_sample'(1), lir_pkg::t_sample'(-2)));
    endtask

    // bypass leaves phase and history alone
    task automatic test_bypass();
        configure(STEP_QUARTER, 1'b1);
        send_frame(make_frame(S_MIN, S_MAX));
        send_frame(make_frame(S_MAX, S_MIN));
        send_frame(rand_frame());
    endtask

    // step above one: some frames produce nothing
    task automatic test_downsampling_gap();
        configure(STEP_2_5, 1'b0);
        repeat (5) send_frame(rand_frame());
    endtask

    // zero and lowest steps run into the per-frame cap, then the top step
    task automatic test_run_cap();
        configure('0, 1'b0);
        send_frame(make_frame(S_MIN, S_MAX));
        send_frame(make_frame(S_MAX, S_MIN));
        configure(STEP_LOWEST, 1'b0);
        send_frame(make_frame(S_MIN, S_MAX));
        send_frame(rand_frame());
        configure(STEP_ALL_SET, 1'b0);
        send_frame(rand_frame());
        send_frame(rand_frame());
    endtask

    // writes past the register file must change nothing
    task automatic test_spare_indexes();
        configure(lir_pkg::PHASE_W'(32'd12582912), 1'b0);
        write_reg(CFG_IDX_SPARE_2, lir_pkg::CFG_DATA_W'($urandom));
        write_reg(CFG_IDX_SPARE_3, lir_pkg::CFG_DATA_W'($urandom));
        send_frame(rand_frame());
        send_frame(rand_frame());
    endtask

    // bursts of random frames, each under a fresh random setting
    task automatic test_random_streams();
        int                          budget;
        int                          burst;
        logic [lir_pkg::PHASE_W-1:0] step;
        budget = RANDOM_ITEMS;
        while (budget > 0) begin
            step = pick_step();
            configure(step, $urandom_range(0, 5) == 0);
            if ($urandom_range(0, 7) == 0)
                write_reg($urandom_range(0, 1) ? CFG_IDX_SPARE_2 : CFG_IDX_SPARE_3,
                          lir_pkg::CFG_DATA_W'($urandom));
            src_idle  = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
            burst     = $urandom_range(15, 40);
            // long runs per frame: keep those bursts short
            if (step < STEP_ONE / 16 && burst > 12)
                burst = 12;
            if (burst > budget)
                burst = budget;
            repeat (burst) send_frame(rand_frame());
            budget -= burst;
        end
    endtask

    // main sequence
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_power_up();
        test_half_step_rounding();
        test_bypass();
        test_downsampling_gap();
        test_run_cap();
        test_spare_indexes();
        test_random_streams();

        wait_idle();
        $display("covered %0d input frames under %0d step/bypass settings, %0d register writes",
                 frames_sent, settings_used, reg_writes);
        $display("checked %0d output samples, %0d mismatches", samples_seen, error_count);
        if (error_count == 0)
            $display("linear_interp_resampler_test: done, clean");
        else
            $display("linear_interp_resampler_test: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
